// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define MWD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define MWD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/mwd_pkg.sv -----
// types and constants of the motion window detector
package mwd_pkg;

  localparam int RANGE_W   = 8;
  localparam int ENTRY_W   = 7;
  localparam int INDEX_W   = 3;
  localparam int HAND_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSION_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VENTILATION_ENABLE = 2'd2;

  localparam logic [ENTRY_W-1:0] SPREAD_RESET = 7'd8;
  localparam logic [ENTRY_W-1:0] ENTRY_MAX    = 7'd127;

  localparam logic CH_COMP = 1'b0;
  localparam logic CH_VENT = 1'b1;

  // divide by ten: (x * 6554) >> 16 is exact for x below 16384
  localparam int SUM_MAX_W  = 12;
  localparam int DIV_MULT_W = 13;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT = 13'd6554;
  localparam int DIV_SHIFT  = 16;
  localparam int PROD_W     = SUM_MAX_W + DIV_MULT_W;
  localparam int QUOT_W     = 9;

  typedef struct packed {
    logic               sensing_on;
    logic [RANGE_W-1:0] compression_range;
    logic               compression_ok;
    logic [RANGE_W-1:0] ventilation_range;
    logic               ventilation_ok;
    logic [HAND_W-1:0]  hand_position;
  } in_item_t;

  typedef struct packed {
    logic               channel;
    logic [ENTRY_W-1:0] sample_value;
    logic [INDEX_W-1:0] sample_index;
    logic [HAND_W-1:0]  frame_hand_position;
    logic [ENTRY_W-1:0] window_peak;
    logic [ENTRY_W-1:0] window_trough;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic ch;
    logic acc;
    logic div;
    logic win;
    logic out_load;
  } mwd_cmd_t;

  typedef struct packed {
    logic sensing;
    logic feed_ok;
    logic group_done;
    logic emit_pending;
    logic emit_last;
    logic out_free;
  } mwd_status_t;

endpackage

// ----- hw/rtl/mwd_stream_if.sv -----
// valid/ready stream interface carrying one payload
interface mwd_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/mwd_ctrl.sv -----
// controller state machine sequencing the channel feeds and frame emission
module mwd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mwd_pkg::mwd_status_t  st,
  output mwd_pkg::mwd_cmd_t     cmd
);
  import mwd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WIN  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       ch_r, ch_nxt;
  logic [2:0] after_ch;

  assign in_ready = (state_r == S_IDLE);
  assign after_ch = (ch_r == CH_COMP) ? S_ACC : S_EMIT;

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    cmd       = '0;
    cmd.ch    = ch_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          ch_nxt      = CH_COMP;
          state_nxt   = S_ACC;
        end
      end
      S_ACC: begin
        if (!st.sensing) begin
          state_nxt = S_IDLE;
        end else if (st.feed_ok && st.group_done) begin
          cmd.acc   = 1'b1;
          state_nxt = S_DIV;
        end else begin
          cmd.acc   = st.feed_ok;
          ch_nxt    = CH_VENT;
          state_nxt = after_ch;
        end
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_WIN;
      end
      S_WIN: begin
        cmd.win   = 1'b1;
        ch_nxt    = CH_VENT;
        state_nxt = after_ch;
      end
      S_EMIT: begin
        if (!st.emit_pending) begin
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (st.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= CH_COMP;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

endmodule

// ----- hw/rtl/mwd_dp.sv -----
// datapath: config registers, group sums, windows, peak/trough and output register
module mwd_dp #(
  parameter int READINGS_PER_ENTRY = 5,
  parameter int WINDOW_LENGTH      = 5
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mwd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mwd_pkg::CFG_DAT_W-1:0]        cfg_wdata,
  input  mwd_pkg::in_item_t                    in_item,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output mwd_pkg::out_item_t                   out_item,
  input  mwd_pkg::mwd_cmd_t                    cmd,
  output mwd_pkg::mwd_status_t                 st
);
  import mwd_pkg::*;

  localparam int RC_W  = (READINGS_PER_ENTRY > 1) ? $clog2(READINGS_PER_ENTRY) : 1;
  localparam int SUM_W = RANGE_W + RC_W;
  localparam int WC_W  = $clog2(WINDOW_LENGTH);

  in_item_t           item_r;
  logic [ENTRY_W-1:0] thr_r;
  logic [1:0]         en_r;
  logic [RC_W-1:0]    rcnt_r  [2];
  logic [SUM_W-1:0]   acc_r   [2];
  logic [WC_W-1:0]    wcnt_r  [2];
  logic [ENTRY_W-1:0] win_r   [2][WINDOW_LENGTH];
  logic [ENTRY_W-1:0] hi_r    [2];
  logic [ENTRY_W-1:0] lo_r    [2];
  logic [ENTRY_W-1:0] peak_r  [2];
  logic [ENTRY_W-1:0] trough_r[2];
  logic [1:0]         pend_r;
  logic               act_r;
  logic [WC_W-1:0]    eidx_r;
  logic [PROD_W-1:0]  prod_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic               sel;
  logic [RANGE_W-1:0] rd;
  logic [SUM_W-1:0]   acc_sum;
  logic               grp_done;
  logic [QUOT_W-1:0]  quot;
  logic [ENTRY_W-1:0] entry;
  logic               first;
  logic [ENTRY_W-1:0] hi_new, lo_new, spread;
  logic               win_full;
  logic               emit_last;

  assign sel      = cmd.ch;
  assign rd       = sel ? item_r.ventilation_range : item_r.compression_range;
  assign acc_sum  = (rcnt_r[sel] == '0) ? SUM_W'(rd) : acc_r[sel] + SUM_W'(rd);
  assign grp_done = (rcnt_r[sel] == RC_W'(READINGS_PER_ENTRY - 1));

  assign quot   = prod_r[DIV_SHIFT +: QUOT_W];
  assign entry  = (quot > QUOT_W'(ENTRY_MAX)) ? ENTRY_MAX : quot[ENTRY_W-1:0];
  assign first  = (wcnt_r[sel] == '0);
  assign hi_new = (first || entry > hi_r[sel]) ? entry : hi_r[sel];
  assign lo_new = (first || entry < lo_r[sel]) ? entry : lo_r[sel];
  assign spread = hi_new - lo_new;
  assign win_full  = (wcnt_r[sel] == WC_W'(WINDOW_LENGTH - 1));
  assign emit_last = (eidx_r == WC_W'(WINDOW_LENGTH - 1));

  assign st.sensing      = item_r.sensing_on;
  assign st.feed_ok      = sel ? (en_r[1] & item_r.ventilation_ok)
                               : (en_r[0] & item_r.compression_ok);
  assign st.group_done   = grp_done;
  assign st.emit_pending = pend_r[act_r];
  assign st.emit_last    = emit_last;
  assign st.out_free     = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= SPREAD_RESET;
      en_r        <= 2'b11;
      rcnt_r      <= '{default: '0};
      wcnt_r      <= '{default: '0};
      peak_r      <= '{default: '0};
      trough_r    <= '{default: '0};
      pend_r      <= '0;
      act_r       <= CH_COMP;
      eidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SPREAD_THRESHOLD:   thr_r   <= cfg_wdata;
          CFG_COMPRESSION_ENABLE: en_r[0] <= cfg_wdata[0];
          CFG_VENTILATION_ENABLE: en_r[1] <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.acc) begin
        rcnt_r[sel] <= grp_done ? '0 : rcnt_r[sel] + RC_W'(1);
      end
      if (cmd.win) begin
        wcnt_r[sel] <= win_full ? '0 : wcnt_r[sel] + WC_W'(1);
        if (win_full) begin
          pend_r[sel]   <= 1'b1;
          peak_r[sel]   <= hi_new;
          trough_r[sel] <= lo_new;
          if (spread > thr_r) begin
            act_r <= sel;
          end
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        eidx_r      <= emit_last ? '0 : eidx_r + WC_W'(1);
        if (emit_last) begin
          pend_r[act_r] <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.acc) begin
      acc_r[sel] <= acc_sum;
    end
    if (cmd.div) begin
      prod_r <= SUM_MAX_W'(acc_r[sel]) * DIV_MULT;
    end
    if (cmd.win) begin
      win_r[sel][wcnt_r[sel]] <= entry;
      hi_r[sel]               <= hi_new;
      lo_r[sel]               <= lo_new;
    end
    if (cmd.out_load) begin
      out_r.channel             <= act_r;
      out_r.sample_value        <= win_r[act_r][eidx_r];
      out_r.sample_index        <= INDEX_W'(eidx_r);
      out_r.frame_hand_position <= (act_r == CH_VENT) ? '0 : item_r.hand_position;
      out_r.window_peak         <= peak_r[act_r];
      out_r.window_trough       <= trough_r[act_r];
      out_r.last                <= emit_last;
    end
  end

endmodule

// ----- hw/rtl/dual_channel_motion_window_detector_unit.sv -----
// top level of the dual-channel motion window detector
//
// in_chan takes one sensor tick per transaction; out_chan returns frame entries,
// one transaction per window entry, last set on the final entry of a frame.
// cfg_we/cfg_index/cfg_wdata write spread threshold (0), compression enable (1)
// and ventilation enable (2); write only while the block is idle.
// A tick is processed by one sequencer that visits compression then ventilation:
// one accumulate step per channel, plus the divide-by-ten multiply and window
// update steps when a five-reading group completes, before the emit check. A
// frame then goes out one entry at a time through the output register. A tick
// with sensing off returns the sequencer to idle. in_chan.ready is high only
// while the sequencer is idle. When the receiver stalls, the output register
// holds its entry and the sequencer waits; a new tick is still taken while the
// final entry waits. Reset is synchronous: counters, pending flags, peak/trough,
// active channel (compression) and config registers return to their reset
// values at a clock edge while rst_n is low.
module dual_channel_motion_window_detector_unit #(
  parameter int READINGS_PER_ENTRY = 5,
  parameter int WINDOW_LENGTH      = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mwd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mwd_pkg::CFG_DAT_W-1:0] cfg_wdata,
  mwd_stream_if.sink                    in_chan,
  mwd_stream_if.source                  out_chan
);
  import mwd_pkg::*;

  mwd_cmd_t    cmd;
  mwd_status_t st;

  mwd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .st       (st),
    .cmd      (cmd)
  );

  mwd_dp #(
    .READINGS_PER_ENTRY (READINGS_PER_ENTRY),
    .WINDOW_LENGTH      (WINDOW_LENGTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_chan.payload),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_item  (out_chan.payload),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// ----- hw/rtl/mwd_checker.sv -----
// port-level assertions for the motion window detector, bound to the top level
`include "assert_macros.svh"

module mwd_checker #(
  parameter int WINDOW_LENGTH = 5
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input mwd_pkg::out_item_t out_item
);
  import mwd_pkg::*;

  `MWD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item), "output changed while stalled")
  `MWD_ASSERT(a_last_index, out_valid && out_item.last |-> out_item.sample_index == INDEX_W'(WINDOW_LENGTH - 1), "last flag on wrong entry")
  `MWD_ASSERT(a_vent_hand, out_valid && out_item.channel == CH_VENT |-> out_item.frame_hand_position == '0, "ventilation frame carries hand position")
  `MWD_ASSERT(a_frame_contig, out_valid && out_ready && !out_item.last |=> out_valid && out_item.sample_index == $past(out_item.sample_index) + INDEX_W'(1), "frame entries not back to back")
  `MWD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind dual_channel_motion_window_detector_unit mwd_checker #(
  .WINDOW_LENGTH (WINDOW_LENGTH)
) u_mwd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_item  (out_chan.payload)
);
